### hdl/kfes_pkg.sv
// shared types and codes for the keyframe easing sampler
`timescale 1ns / 1ps
package kfes_pkg;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [2:0] EASE_LINEAR = 3'd0;
    localparam logic [2:0] EASE_IN     = 3'd1;
    localparam logic [2:0] EASE_OUT    = 3'd2;
    localparam logic [2:0] EASE_INOUT  = 3'd3;
    localparam logic [2:0] EASE_STRONG = 3'd4;

    localparam logic [1:0] REG_CLIP_DURATION  = 2'd0;
    localparam logic [1:0] REG_LOOP_LIMIT     = 2'd1;
    localparam logic [1:0] REG_KEYFRAME_COUNT = 2'd2;

    typedef struct packed {
        logic [2:0]  easing;
        logic [15:0] value;
        logic [15:0] ktime;
    } key_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

### hdl/kfes_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module kfes_div (
    input  logic              clk,
    input  logic              rst_n,
    input  kfes_pkg::div_req_t req,
    output kfes_pkg::div_rsp_t rsp
);
    import kfes_pkg::*;

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [16:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hdl/keyframe_easing_sampler_unit.sv
// keyframe easing sampler top level
// One item is taken at a time. A load item, a stop item or a tick while stopped puts its
// result in the output register at the edge that takes it. A sampling item (play, hold,
// tick) first waits on the shared divider when a tick wraps the clip, then starts and
// reads the first keyframe (done here when the time is at or before it, or with one key),
// then reads the last keyframe (done here when the time is at or after it), then scans
// the keyframes one at a time, up to keyframe_count - 1 of them. The segment position
// waits on the divider, easing squares once (in, out, in-out) or twice (strong out) or
// not at all (linear), and the blend multiplies and then rounds and adds.
// The longest item is a wrapping tick with 16 keys and strong out easing; the divider and
// the keyframe scan take most of its time. The result sits in an output register; the
// next item is taken once it has been delivered.
`timescale 1ns / 1ps
module keyframe_easing_sampler_unit #(
    parameter int MAX_KEYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // key_index[3:0] key_time[19:4] key_value[35:20] key_easing[38:36]
    // delta_ticks[54:39] hold[55]
    input  logic [55:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_value[15:0] applied[16] playing[17] finished[18]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import kfes_pkg::*;

    localparam int IDXW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNTW = $clog2(MAX_KEYS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CDIV  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_RD0   = 4'd3;
    localparam logic [3:0] S_RDL   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_UDIV  = 4'd6;
    localparam logic [3:0] S_EMUL  = 4'd7;
    localparam logic [3:0] S_EPOST = 4'd8;
    localparam logic [3:0] S_BMUL  = 4'd9;
    localparam logic [3:0] S_BFIN  = 4'd10;

    // input fields
    logic [1:0]  mode;
    logic [3:0]  key_index;
    logic [15:0] key_time;
    logic [15:0] key_value;
    logic [2:0]  key_easing;
    logic [15:0] delta_ticks;
    logic        hold;

    assign mode        = s_tuser;
    assign key_index   = s_tdata[3:0];
    assign key_time    = s_tdata[19:4];
    assign key_value   = s_tdata[35:20];
    assign key_easing  = s_tdata[38:36];
    assign delta_ticks = s_tdata[54:39];
    assign hold        = s_tdata[55];

    // configuration
    logic [15:0] clip_duration_reg;
    logic [15:0] loop_limit_reg;
    logic [4:0]  keyframe_count_reg;

    // control state
    logic [3:0]      state_reg;
    logic            active_reg;
    logic [16:0]     clip_time_reg;
    logic [15:0]     loops_done_reg;
    logic            fin_reg;
    logic            phase_reg;
    logic [CNTW-1:0] idx_reg;
    logic [CNTW-1:0] n_reg;
    logic            out_valid_reg;

    // datapath
    logic [16:0] smp_t_reg;
    logic [16:0] tt_reg;
    key_entry_t  prev_reg;
    logic [15:0] v1_reg;
    logic [15:0] vlast_reg;
    logic [16:0] u_reg;
    logic [16:0] v_reg;
    logic [16:0] e_reg;
    logic [33:0] prod_reg;
    logic signed [34:0] bprod_reg;
    logic [15:0] out_val_reg;
    logic        out_app_reg;
    logic        out_play_reg;
    logic        out_fin_reg;

    // keyframe memory
    key_entry_t key_mem [MAX_KEYS];
    key_entry_t rd_data;
    logic [IDXW-1:0] rd_addr;
    logic            mem_we;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic        s_acc;
    logic [16:0] t_sum;
    logic [17:0] loops_sum;
    logic [15:0] r_left;
    logic [16:0] mul_x;
    logic [16:0] sq16;
    logic [2:0]  ecode;
    logic [16:0] diff;
    logic signed [34:0] bround;
    logic [CNTW-1:0] n_next;
    logic [16:0] dur17;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign mem_we   = s_acc && (mode == MODE_LOAD) && (int'(key_index) < MAX_KEYS);
    assign dur17    = {1'b0, clip_duration_reg};
    assign t_sum    = clip_time_reg + {1'b0, delta_ticks};
    assign loops_sum = {2'b0, loops_done_reg} + {1'b0, div_rsp.quotient[16:0]};
    assign r_left   = ({1'b0, loops_done_reg} + 17'd1 >= {1'b0, loop_limit_reg}) ? 16'd0
                      : 16'(loop_limit_reg - 16'd1 - loops_done_reg);
    assign n_next   = (int'(keyframe_count_reg) > MAX_KEYS) ? CNTW'(MAX_KEYS)
                      : CNTW'(keyframe_count_reg);
    assign ecode    = prev_reg.easing;
    assign sq16     = 17'((prod_reg + 34'd32768) >> 16);
    assign diff     = {v1_reg[15], v1_reg} - {prev_reg.value[15], prev_reg.value};
    assign bround   = (bprod_reg + 35'sd32768) >>> 16;

    always_comb
    begin
        case (ecode)
            EASE_IN:     mul_x = u_reg;
            EASE_OUT:    mul_x = 17'd65536 - u_reg;
            EASE_INOUT:  mul_x = (u_reg < 17'd32768) ? u_reg
                                 : 17'(18'd131072 - {u_reg, 1'b0});
            EASE_STRONG: mul_x = phase_reg ? v_reg : 17'd65536 - u_reg;
            default:     mul_x = u_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_START: rd_addr = '0;
            S_RD0:   rd_addr = IDXW'(n_reg - 1'b1);
            S_RDL:   rd_addr = IDXW'(1);
            S_SCAN:  rd_addr = IDXW'(idx_reg + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[IDXW'(key_index)] <= '{easing: key_easing, value: key_value,
                                           ktime: key_time};
        end
        rd_data <= key_mem[rd_addr];
    end

    always_comb
    begin
        div_req = '0;
        if (state_reg == S_IDLE && s_acc && mode == MODE_TICK && active_reg && !hold
            && clip_duration_reg != 16'd0 && t_sum >= dur17)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = {15'd0, t_sum};
            div_req.divisor  = clip_duration_reg;
        end
        else if (state_reg == S_SCAN && tt_reg >= {1'b0, prev_reg.ktime}
                 && tt_reg <= {1'b0, rd_data.ktime})
        begin
            div_req.start    = 1'b1;
            div_req.dividend = {16'(tt_reg[15:0] - prev_reg.ktime), 16'd0};
            div_req.divisor  = (rd_data.ktime > prev_reg.ktime)
                               ? 16'(rd_data.ktime - prev_reg.ktime) : 16'd1;
        end
    end

    kfes_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            active_reg         <= 1'b0;
            clip_time_reg      <= '0;
            loops_done_reg     <= '0;
            fin_reg            <= 1'b0;
            phase_reg          <= 1'b0;
            idx_reg            <= '0;
            n_reg              <= '0;
            out_valid_reg      <= 1'b0;
            clip_duration_reg  <= '0;
            loop_limit_reg     <= '0;
            keyframe_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CLIP_DURATION:  clip_duration_reg  <= cfg_wdata;
                    REG_LOOP_LIMIT:     loop_limit_reg     <= cfg_wdata;
                    REG_KEYFRAME_COUNT: keyframe_count_reg <= cfg_wdata[4:0];
                    default:            ;
                endcase
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        fin_reg <= 1'b0;
                        case (mode)
                            MODE_PLAY:
                            begin
                                clip_time_reg  <= '0;
                                loops_done_reg <= '0;
                                active_reg     <= 1'b1;
                                state_reg      <= S_START;
                            end
                            MODE_STOP:
                            begin
                                active_reg    <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                            MODE_TICK:
                            begin
                                if (!active_reg)
                                begin
                                    out_valid_reg <= 1'b1;
                                end
                                else if (hold)
                                begin
                                    state_reg <= S_START;
                                end
                                else if (clip_duration_reg == 16'd0)
                                begin
                                    active_reg <= 1'b0;
                                    fin_reg    <= 1'b1;
                                    state_reg  <= S_START;
                                end
                                else if (t_sum >= dur17)
                                begin
                                    state_reg <= S_CDIV;
                                end
                                else
                                begin
                                    clip_time_reg <= t_sum;
                                    state_reg     <= S_START;
                                end
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CDIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_START;
                        if (loop_limit_reg == 16'd0)
                        begin
                            loops_done_reg <= (loops_sum > 18'd65535) ? 16'hFFFF
                                              : loops_sum[15:0];
                            clip_time_reg  <= {1'b0, div_rsp.remainder};
                        end
                        else if (div_rsp.quotient[16:0] > {1'b0, r_left})
                        begin
                            loops_done_reg <= loops_done_reg + r_left;
                            clip_time_reg  <= dur17;
                            fin_reg        <= 1'b1;
                            active_reg     <= 1'b0;
                        end
                        else
                        begin
                            loops_done_reg <= loops_sum[15:0];
                            clip_time_reg  <= {1'b0, div_rsp.remainder};
                        end
                    end
                end
                S_START:
                begin
                    n_reg <= n_next;
                    if (n_next == '0)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    if (n_reg == CNTW'(1) || tt_reg <= {1'b0, rd_data.ktime})
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RDL;
                    end
                end
                S_RDL:
                begin
                    if (tt_reg >= {1'b0, rd_data.ktime})
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= CNTW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (div_req.start)
                    begin
                        state_reg <= S_UDIV;
                    end
                    else if (idx_reg + 1'b1 < n_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_UDIV:
                begin
                    phase_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        if (ecode inside {EASE_IN, EASE_OUT, EASE_INOUT, EASE_STRONG})
                        begin
                            state_reg <= S_EMUL;
                        end
                        else
                        begin
                            state_reg <= S_BMUL;
                        end
                    end
                end
                S_EMUL:
                begin
                    state_reg <= S_EPOST;
                end
                S_EPOST:
                begin
                    if (ecode == EASE_STRONG && !phase_reg)
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= S_EMUL;
                    end
                    else
                    begin
                        state_reg <= S_BMUL;
                    end
                end
                S_BMUL:
                begin
                    state_reg <= S_BFIN;
                end
                S_BFIN:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    out_app_reg <= 1'b0;
                    out_val_reg <= '0;
                    if (mode == MODE_PLAY || clip_duration_reg == 16'd0)
                    begin
                        smp_t_reg <= '0;
                    end
                    else if (hold || t_sum >= dur17)
                    begin
                        smp_t_reg <= clip_time_reg;
                    end
                    else
                    begin
                        smp_t_reg <= t_sum;
                    end
                    out_play_reg <= (mode == MODE_PLAY) ? 1'b1
                                    : (mode == MODE_STOP) ? 1'b0 : active_reg;
                    out_fin_reg  <= 1'b0;
                end
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    if (loop_limit_reg != 16'd0
                        && div_rsp.quotient[16:0] > {1'b0, r_left})
                    begin
                        smp_t_reg <= dur17;
                    end
                    else
                    begin
                        smp_t_reg <= {1'b0, div_rsp.remainder};
                    end
                end
            end
            S_START:
            begin
                tt_reg       <= (smp_t_reg > dur17) ? dur17 : smp_t_reg;
                out_play_reg <= active_reg;
                out_fin_reg  <= fin_reg;
                out_app_reg  <= (n_next != '0);
                out_val_reg  <= '0;
            end
            S_RD0:
            begin
                prev_reg    <= rd_data;
                out_val_reg <= rd_data.value;
            end
            S_RDL:
            begin
                vlast_reg   <= rd_data.value;
                out_val_reg <= rd_data.value;
            end
            S_SCAN:
            begin
                if (div_req.start)
                begin
                    v1_reg <= rd_data.value;
                end
                else
                begin
                    prev_reg    <= rd_data;
                    out_val_reg <= vlast_reg;
                end
            end
            S_UDIV:
            begin
                u_reg <= (div_rsp.quotient > 32'd65536) ? 17'd65536
                         : div_rsp.quotient[16:0];
                e_reg <= (div_rsp.quotient > 32'd65536) ? 17'd65536
                         : div_rsp.quotient[16:0];
            end
            S_EMUL:
            begin
                prod_reg <= {17'd0, mul_x} * {17'd0, mul_x};
            end
            S_EPOST:
            begin
                case (ecode)
                    EASE_IN:     e_reg <= sq16;
                    EASE_OUT:    e_reg <= 17'd65536 - sq16;
                    EASE_INOUT:
                    begin
                        if (u_reg < 17'd32768)
                        begin
                            e_reg <= 17'((prod_reg + 34'd16384) >> 15);
                        end
                        else
                        begin
                            e_reg <= 17'd65536 - 17'((prod_reg + 34'd65536) >> 17);
                        end
                    end
                    EASE_STRONG:
                    begin
                        v_reg <= sq16;
                        e_reg <= 17'd65536 - sq16;
                    end
                    default:     e_reg <= u_reg;
                endcase
            end
            S_BMUL:
            begin
                bprod_reg <= $signed(diff) * $signed({1'b0, e_reg});
            end
            S_BFIN:
            begin
                out_val_reg <= 16'(prev_reg.value + bround[15:0]);
            end
            default:
            begin
                out_val_reg <= out_val_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_fin_reg, out_play_reg, out_app_reg, out_val_reg};

    a_fin_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fin_reg) |-> !out_play_reg)
        else $error("finished result still reports playing");

    a_unapplied_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_app_reg) |-> (out_val_reg == 16'd0))
        else $error("unapplied result carries a value");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> (state_reg != S_IDLE || out_valid_reg))
        else $error("accepted item left no work and no result");

endmodule
